>>> hdl/wspd_pkg.sv
// Package for the wheel speed PID duty controller: payload structs, register
// indexes, fixed widths and the microprogram ROM of the sequencer.
// No dependencies.
package wspd_pkg;

    localparam int WORD_W      = 32;
    localparam int INTEG_W     = 48;
    localparam int DUTY_W      = 22;
    localparam int PERIOD_W    = 31;
    localparam int CFG_INDEX_W = 3;
    localparam int STEP_W      = 4;

    // The shared multiplier takes one 24-bit half of a 48-bit operand per pass.
    localparam int HALF_W      = 24;
    localparam int MUL_A_W     = HALF_W + 1;
    localparam int MUL_B_W     = WORD_W + 1;
    localparam int PROD_W      = MUL_A_W + MUL_B_W;
    localparam int HI_CLAMP_W  = 42;
    localparam int PART_W      = HI_CLAMP_W + HALF_W + 1;
    localparam int SUM_W       = WORD_W + 2;
    localparam int CLAMP_W     = WORD_W + 2;

    localparam int DUTY_TOP    = 60;
    localparam int DUTY_MARGIN = 5;

    localparam logic [PERIOD_W-1:0] SAMPLE_PERIOD_RST  = PERIOD_W'(6554);
    localparam logic [PERIOD_W-1:0] INVERSE_PERIOD_RST = PERIOD_W'(655360);
    localparam logic [DUTY_W-1:0]   BASE_DUTY_RST      = DUTY_W'(1310720);

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_GAIN_P,
        REG_GAIN_I,
        REG_GAIN_D,
        REG_SAMPLE_PERIOD,
        REG_INVERSE_PERIOD,
        REG_BASE_DUTY
    } cfg_reg_t;

    typedef enum logic {
        KIND_RESTART,
        KIND_SAMPLE
    } kind_t;

    typedef struct packed {
        kind_t                     kind;
        logic signed [WORD_W-1:0]  target_speed;
        logic signed [WORD_W-1:0]  measured_speed;
    } wspd_item_t;

    typedef struct packed {
        logic [DUTY_W-1:0]         duty_out;
        logic signed [WORD_W-1:0]  control_out;
    } wspd_result_t;

    // Control word fields.
    typedef enum logic [1:0] {
        X_ERR,
        X_DIFF,
        X_TERM,
        X_INTEG
    } xsel_t;

    typedef enum logic {
        HALF_LO,
        HALF_HI
    } half_t;

    typedef enum logic [2:0] {
        K_PERIOD,
        K_INVERSE,
        K_GAIN_P,
        K_GAIN_I,
        K_GAIN_D
    } ksel_t;

    typedef enum logic [1:0] {
        P_HOLD,
        P_LOAD,
        P_ADD
    } pop_t;

    typedef enum logic [2:0] {
        WB_NONE,
        WB_INTEG,
        WB_TERM,
        WB_SUM_SET,
        WB_SUM_ADD,
        WB_ACC,
        WB_RESTART,
        WB_FINAL
    } wb_t;

    typedef enum logic [1:0] {
        JMP_NONE,
        JMP_RESTART,
        JMP_ALWAYS
    } jmp_t;

    typedef logic [STEP_W-1:0] step_t;

    typedef struct packed {
        xsel_t  xsel;
        half_t  half;
        ksel_t  ksel;
        pop_t   pop;
        wb_t    wb;
        jmp_t   jmp;
        step_t  target;
        logic   done;
    } ucode_t;

    localparam step_t STEP_FINAL   = step_t'(13);
    localparam step_t STEP_RESTART = step_t'(14);
    localparam step_t STEP_LAST    = STEP_RESTART;

    localparam ucode_t UCODE_NOP =
        '{X_ERR, HALF_LO, K_PERIOD, P_HOLD, WB_NONE, JMP_NONE, '0, 1'b0};

    // Each product takes three steps: high half, low half with the high
    // partial loaded, then the low partial added. Write-back comes in the
    // step after the add, so consecutive products overlap.
    function automatic ucode_t ucode_rom(input step_t step);
        ucode_t w;
        w = UCODE_NOP;
        case (step)
            step_t'(0):  w = '{X_ERR,  HALF_HI, K_PERIOD,  P_HOLD, WB_NONE,
                               JMP_RESTART, STEP_RESTART, 1'b0};
            step_t'(1):  w = '{X_ERR,  HALF_LO, K_PERIOD,  P_LOAD, WB_NONE,
                               JMP_NONE, '0, 1'b0};
            step_t'(2):  w = '{X_DIFF, HALF_HI, K_GAIN_D,  P_ADD,  WB_NONE,
                               JMP_NONE, '0, 1'b0};
            step_t'(3):  w = '{X_DIFF, HALF_LO, K_GAIN_D,  P_LOAD, WB_INTEG,
                               JMP_NONE, '0, 1'b0};
            step_t'(4):  w = '{X_ERR,  HALF_HI, K_GAIN_P,  P_ADD,  WB_NONE,
                               JMP_NONE, '0, 1'b0};
            step_t'(5):  w = '{X_ERR,  HALF_LO, K_GAIN_P,  P_LOAD, WB_TERM,
                               JMP_NONE, '0, 1'b0};
            step_t'(6):  w = '{X_TERM, HALF_HI, K_INVERSE, P_ADD,  WB_NONE,
                               JMP_NONE, '0, 1'b0};
            step_t'(7):  w = '{X_TERM, HALF_LO, K_INVERSE, P_LOAD, WB_SUM_SET,
                               JMP_NONE, '0, 1'b0};
            step_t'(8):  w = '{X_INTEG, HALF_HI, K_GAIN_I, P_ADD,  WB_NONE,
                               JMP_NONE, '0, 1'b0};
            step_t'(9):  w = '{X_INTEG, HALF_LO, K_GAIN_I, P_LOAD, WB_SUM_ADD,
                               JMP_NONE, '0, 1'b0};
            step_t'(10): w = '{X_ERR,  HALF_LO, K_PERIOD,  P_ADD,  WB_NONE,
                               JMP_NONE, '0, 1'b0};
            step_t'(11): w = '{X_ERR,  HALF_LO, K_PERIOD,  P_HOLD, WB_SUM_ADD,
                               JMP_NONE, '0, 1'b0};
            step_t'(12): w = '{X_ERR,  HALF_LO, K_PERIOD,  P_HOLD, WB_ACC,
                               JMP_NONE, '0, 1'b0};
            step_t'(13): w = '{X_ERR,  HALF_LO, K_PERIOD,  P_HOLD, WB_FINAL,
                               JMP_NONE, '0, 1'b1};
            step_t'(14): w = '{X_ERR,  HALF_LO, K_PERIOD,  P_HOLD, WB_RESTART,
                               JMP_ALWAYS, STEP_FINAL, 1'b0};
            default:     w = UCODE_NOP;
        endcase
        return w;
    endfunction

endpackage

>>> hdl/wheel_speed_pid_duty.sv
// Sample item: runs steps 0 to 13; no new item is taken until it is done.
// Restart item: jumps from step 0 to the restart step, then to the final step.
// One shared 25x33 multiplier, run ten times per sample (two halves for each of five
// products), sets the run length: one step per cycle, held while the output is full.
// Reset loads the register defaults and clears the integral, previous error and
// duty accumulator at once; no clearing pass is needed.
//
// Top level of the wheel speed PID duty controller: microcoded sequencer and datapath.
// Depends on wspd_pkg for payload types, control word layout and the program ROM.
module wheel_speed_pid_duty
    import wspd_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    item_valid,
    output logic                    item_ready,
    input  wspd_item_t              item,
    output logic                    result_valid,
    input  logic                    result_ready,
    output wspd_result_t            result,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_INDEX_W-1:0]  cfg_index,
    input  logic [WORD_W-1:0]       cfg_data
);

    localparam logic signed [PROD_W-1:0] HI_MAX = PROD_W'(1) <<< (HI_CLAMP_W - 2);
    localparam logic signed [PROD_W-1:0] HI_MIN = -HI_MAX;
    localparam logic signed [CLAMP_W-1:0] DUTY_TOP_Q =
        CLAMP_W'(DUTY_TOP) <<< FRAC_BITS;
    localparam logic signed [CLAMP_W-1:0] DUTY_MARGIN_Q =
        CLAMP_W'(DUTY_MARGIN) <<< FRAC_BITS;

    function automatic logic signed [WORD_W-1:0] sat_word(
        input logic signed [PART_W-1:0] v
    );
        logic [PART_W-WORD_W:0] top;
        top = v[PART_W-1:WORD_W-1];
        if ((&top) || !(|top))
            return v[WORD_W-1:0];
        return v[PART_W-1] ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
    endfunction

    function automatic logic signed [INTEG_W-1:0] sat_integ(
        input logic signed [PART_W-1:0] v
    );
        logic [PART_W-INTEG_W:0] top;
        top = v[PART_W-1:INTEG_W-1];
        if ((&top) || !(|top))
            return v[INTEG_W-1:0];
        return v[PART_W-1] ? {1'b1, {(INTEG_W-1){1'b0}}} : {1'b0, {(INTEG_W-1){1'b1}}};
    endfunction

    // Configuration registers
    logic signed [WORD_W-1:0]   gain_p_reg, gain_i_reg, gain_d_reg;
    logic [PERIOD_W-1:0]        period_reg, inverse_reg;
    logic [DUTY_W-1:0]          base_reg;

    // Sequencer and controller state
    logic                       busy_reg, busy_next;
    step_t                      pc_reg, pc_next;
    logic                       result_valid_reg, result_valid_next;
    logic signed [INTEG_W-1:0]  integ_reg, integ_next;
    logic signed [WORD_W-1:0]   prev_reg, prev_next;
    logic signed [WORD_W-1:0]   acc_reg, acc_next;

    // Datapath payload
    kind_t                      kind_reg, kind_next;
    logic signed [WORD_W-1:0]   err_reg, err_next;
    logic signed [WORD_W-1:0]   term_reg, term_next;
    logic signed [SUM_W-1:0]    sum_reg, sum_next;
    logic signed [WORD_W-1:0]   u_reg, u_next;
    logic signed [PROD_W-1:0]   prod_reg, prod_next;
    logic signed [PART_W-1:0]   part_reg, part_next;
    wspd_result_t               result_reg, result_next;

    ucode_t                     ctrl;
    logic                       item_take, out_free, stall, run, jump_taken;
    logic signed [WORD_W:0]     diff_in, diff_err;
    logic signed [INTEG_W-1:0]  x_op;
    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic signed [HI_CLAMP_W-1:0] hi_clamp;
    logic signed [PART_W-1:0]   part_shift;
    logic signed [WORD_W-1:0]   part_sat;
    logic signed [CLAMP_W-1:0]  low_raw, duty_low, acc_ext, duty_sel;

    assign ctrl         = ucode_rom(pc_reg);
    assign item_ready   = !busy_reg;
    assign cfg_ready    = 1'b1;
    assign item_take    = item_valid && !busy_reg;
    assign out_free     = !result_valid_reg || result_ready;
    assign stall        = ctrl.done && !out_free;
    assign run          = busy_reg && !stall;
    assign jump_taken   = (ctrl.jmp == JMP_ALWAYS) ||
                          ((ctrl.jmp == JMP_RESTART) && (kind_reg == KIND_RESTART));
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Operand selection for the shared multiplier
    assign diff_in  = {item.target_speed[WORD_W-1], item.target_speed}
                    - {item.measured_speed[WORD_W-1], item.measured_speed};
    assign diff_err = {err_reg[WORD_W-1], err_reg} - {prev_reg[WORD_W-1], prev_reg};

    always_comb
    begin
        unique case (ctrl.xsel)
            X_ERR:   x_op = {{(INTEG_W-WORD_W){err_reg[WORD_W-1]}}, err_reg};
            X_DIFF:  x_op = {{(INTEG_W-WORD_W-1){diff_err[WORD_W]}}, diff_err};
            X_TERM:  x_op = {{(INTEG_W-WORD_W){term_reg[WORD_W-1]}}, term_reg};
            X_INTEG: x_op = integ_reg;
            default: x_op = integ_reg;
        endcase
    end

    always_comb
    begin
        unique case (ctrl.ksel)
            K_PERIOD:  mul_b = {2'b00, period_reg};
            K_INVERSE: mul_b = {2'b00, inverse_reg};
            K_GAIN_P:  mul_b = {gain_p_reg[WORD_W-1], gain_p_reg};
            K_GAIN_I:  mul_b = {gain_i_reg[WORD_W-1], gain_i_reg};
            K_GAIN_D:  mul_b = {gain_d_reg[WORD_W-1], gain_d_reg};
            default:   mul_b = '0;
        endcase
    end

    assign mul_a = (ctrl.half == HALF_HI) ? {x_op[INTEG_W-1], x_op[INTEG_W-1:HALF_W]}
                                          : {1'b0, x_op[HALF_W-1:0]};
    assign prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);

    // The high partial is bounded before weighting; a bounded value still
    // saturates every result the same way.
    always_comb
    begin
        if (prod_reg > HI_MAX)
            hi_clamp = HI_MAX[HI_CLAMP_W-1:0];
        else if (prod_reg < HI_MIN)
            hi_clamp = HI_MIN[HI_CLAMP_W-1:0];
        else
            hi_clamp = prod_reg[HI_CLAMP_W-1:0];
    end

    always_comb
    begin
        case (ctrl.pop)
            P_LOAD:  part_next = PART_W'(hi_clamp) <<< HALF_W;
            P_ADD:   part_next = part_reg + PART_W'(prod_reg);
            default: part_next = part_reg;
        endcase
    end

    assign part_shift = part_reg >>> FRAC_BITS;
    assign part_sat   = sat_word(part_shift);

    // Duty clamp: the upper bound wins, and a negative lower bound becomes zero.
    assign low_raw  = CLAMP_W'({1'b0, base_reg}) - DUTY_MARGIN_Q;
    assign duty_low = low_raw[CLAMP_W-1] ? '0 : low_raw;
    assign acc_ext  = CLAMP_W'(acc_reg);

    always_comb
    begin
        if (acc_ext >= DUTY_TOP_Q)
            duty_sel = DUTY_TOP_Q;
        else if (acc_ext <= duty_low)
            duty_sel = duty_low;
        else
            duty_sel = acc_ext;
    end

    // Sequencer and write-back
    always_comb
    begin
        busy_next         = busy_reg;
        pc_next           = pc_reg;
        result_valid_next = result_valid_reg;
        integ_next        = integ_reg;
        prev_next         = prev_reg;
        acc_next          = acc_reg;
        kind_next         = kind_reg;
        err_next          = err_reg;
        term_next         = term_reg;
        sum_next          = sum_reg;
        u_next            = u_reg;
        result_next       = result_reg;

        if (result_ready)
            result_valid_next = 1'b0;

        if (item_take)
        begin
            busy_next = 1'b1;
            pc_next   = '0;
            kind_next = item.kind;
            err_next  = sat_word(PART_W'(diff_in));
        end

        if (run)
        begin
            if (ctrl.done)
            begin
                busy_next = 1'b0;
                pc_next   = '0;
            end
            else if (jump_taken)
                pc_next = ctrl.target;
            else
                pc_next = pc_reg + step_t'(1);

            case (ctrl.wb)
                WB_INTEG:   integ_next = sat_integ(PART_W'(integ_reg) + part_shift);
                WB_TERM:    term_next  = part_sat;
                WB_SUM_SET: sum_next   = SUM_W'(part_sat);
                WB_SUM_ADD: sum_next   = sum_reg + SUM_W'(part_sat);
                WB_ACC:
                begin
                    u_next    = sat_word(PART_W'(sum_reg));
                    acc_next  = sat_word(PART_W'(acc_reg) + PART_W'(u_next));
                    prev_next = err_reg;
                end
                WB_RESTART:
                begin
                    integ_next = '0;
                    prev_next  = '0;
                    acc_next   = WORD_W'(base_reg);
                    u_next     = '0;
                end
                WB_FINAL:
                begin
                    result_next.duty_out    = duty_sel[DUTY_W-1:0];
                    result_next.control_out = u_reg;
                    result_valid_next       = 1'b1;
                end
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg       <= '0;
            gain_i_reg       <= '0;
            gain_d_reg       <= '0;
            period_reg       <= SAMPLE_PERIOD_RST;
            inverse_reg      <= INVERSE_PERIOD_RST;
            base_reg         <= BASE_DUTY_RST;
            busy_reg         <= 1'b0;
            pc_reg           <= '0;
            result_valid_reg <= 1'b0;
            integ_reg        <= '0;
            prev_reg         <= '0;
            acc_reg          <= '0;
        end
        else
        begin
            busy_reg         <= busy_next;
            pc_reg           <= pc_next;
            result_valid_reg <= result_valid_next;
            integ_reg        <= integ_next;
            prev_reg         <= prev_next;
            acc_reg          <= acc_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_GAIN_P:         gain_p_reg  <= cfg_data;
                    REG_GAIN_I:         gain_i_reg  <= cfg_data;
                    REG_GAIN_D:         gain_d_reg  <= cfg_data;
                    REG_SAMPLE_PERIOD:  period_reg  <= cfg_data[PERIOD_W-1:0];
                    REG_INVERSE_PERIOD: inverse_reg <= cfg_data[PERIOD_W-1:0];
                    REG_BASE_DUTY:      base_reg    <= cfg_data[DUTY_W-1:0];
                    default:            ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        err_reg    <= err_next;
        term_reg   <= term_next;
        sum_reg    <= sum_next;
        u_reg      <= u_next;
        prod_reg   <= prod_next;
        part_reg   <= part_next;
        result_reg <= result_next;
    end

`ifndef SYNTHESIS
    a_pc_in_program: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (pc_reg <= STEP_LAST))
        else $error("step counter left the program");

    a_idle_pc_home: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> (pc_reg == '0))
        else $error("step counter not at entry while idle");

    a_final_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && ctrl.done && out_free) |=> (result_valid_reg && !busy_reg))
        else $error("final step did not hand a result to the output register");

    a_final_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && ctrl.done && !out_free) |=> (busy_reg && $stable(pc_reg)))
        else $error("final step moved on while the output register was full");

    a_restart_path: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready && (item.kind == KIND_RESTART))
            |-> ##3 (busy_reg && (pc_reg == STEP_FINAL)))
        else $error("restart transaction did not reach the final step in time");
`endif

endmodule
